FILE: hw/rtl/ist_pkg.sv
// Shared constants, codes and control structs for the image sub-window tiler.
// No dependencies.
`timescale 1ns / 1ps

package ist_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 12;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_END   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_START = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_END   = 2'd3;

    typedef logic [1:0] t_dsrc;
    localparam t_dsrc DSRC_NUM = 2'd0;
    localparam t_dsrc DSRC_X0  = 2'd1;
    localparam t_dsrc DSRC_X1  = 2'd2;

    typedef struct packed {
        logic  ld_in;
        logic  mul_b;
        logic  step;
        logic  div_go;
        logic  div_take;
        t_dsrc div_src;
        logic  mul_x;
        logic  mul_y;
        logic  ybnd;
        logic  push;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic split_more;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/ist_if.sv
// Valid/ready channel interfaces for tile requests and sub-window results.
// No dependencies.
`timescale 1ns / 1ps

interface ist_req_if #(
    parameter int COUNT_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] tile_number;
    logic [COUNT_BITS:0]   tile_count;

    modport source (output valid, output tile_number, output tile_count, input ready);
    modport sink   (input valid, input tile_number, input tile_count, output ready);
endinterface

interface ist_rsp_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] sub_x_start;
    logic [COORD_BITS-1:0] sub_x_end;
    logic [COORD_BITS-1:0] sub_y_start;
    logic [COORD_BITS-1:0] sub_y_end;
    logic                  out_of_range;

    modport source (output valid, output sub_x_start, output sub_x_end, output sub_y_start,
                    output sub_y_end, output out_of_range, input ready);
    modport sink   (input valid, input sub_x_start, input sub_x_end, input sub_y_start,
                    input sub_y_end, input out_of_range, output ready);
endinterface

FILE: hw/rtl/image_subwindow_tiler.sv
// Top level of the image sub-window tiler: controller, datapath and channel ports.
// Depends on ist_pkg, ist_if, ist_ctrl and ist_dp.
//
//   channel   direction  carries
//   i_req     in         tile_number, tile_count
//   o_rsp     out        sub_x_start, sub_x_end, sub_y_start, sub_y_end, out_of_range
//   i_cfg_*   in         window_x_start, window_x_end, window_y_start, window_y_end
//
// One item at a time. An in-range item runs the column halvings and three divisions on the
// shared divider, which gives one quotient bit per cycle; an out-of-range item skips them.
// A result waits in the output register while the next item is taken in. Reset is
// synchronous, active low, and clears the window registers.
`timescale 1ns / 1ps

module image_subwindow_tiler
    import ist_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    ist_req_if.sink                 i_req,
    ist_rsp_if.source               o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    ist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ist_dp #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_tile_number  (i_req.tile_number),
        .i_tile_count   (i_req.tile_count),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_sub_x_start  (o_rsp.sub_x_start),
        .o_sub_x_end    (o_rsp.sub_x_end),
        .o_sub_y_start  (o_rsp.sub_y_start),
        .o_sub_y_end    (o_rsp.sub_y_end),
        .o_out_of_range (o_rsp.out_of_range)
    );

    assign i_req.ready = w_ready;

endmodule

FILE: hw/rtl/ist_div.sv
// Restoring divider, one quotient bit per cycle.
// Needs the dividend's high part above QW bits to lie below the divisor.
`timescale 1ns / 1ps

module ist_div #(
    parameter int DW = 30,
    parameter int CW = 13,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic [QW-1:0] o_quot,
    output logic [CW-1:0] o_rem,
    output logic          o_done
);
    localparam int SW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [QW-1:0] r_dvd;
    logic [CW-1:0] r_div;

    logic [DW-1:0] w_hi;
    logic [CW:0]   w_trial;
    logic [CW:0]   w_diff;
    logic          w_ge;
    logic [CW-1:0] n_rem;

    assign w_hi    = i_dividend >> QW;
    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= w_hi[CW-1:0];
                r_dvd  <= i_dividend[QW-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[QW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_dvd;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

FILE: hw/rtl/ist_dp.sv
// Datapath: window registers, tile split, shared multiplier and divider, result register.
// Depends on ist_pkg and ist_div.
`timescale 1ns / 1ps

module ist_dp
    import ist_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    input  logic [COUNT_BITS-1:0]   i_tile_number,
    input  logic [COUNT_BITS:0]     i_tile_count,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [COORD_BITS-1:0]   o_sub_x_start,
    output logic [COORD_BITS-1:0]   o_sub_x_end,
    output logic [COORD_BITS-1:0]   o_sub_y_start,
    output logic [COORD_BITS-1:0]   o_sub_y_end,
    output logic                    o_out_of_range
);
    localparam int C  = COORD_BITS;
    localparam int N  = COUNT_BITS;
    localparam int CW = N + 1;
    localparam int PW = C + N + 2;
    localparam int QW = (C > N) ? C : N;
    localparam int KW = $clog2(N + 1);

    logic [C-1:0]  r_xs, r_xe, r_ys, r_ye;
    logic [N-1:0]  r_num;
    logic [CW-1:0] r_count;
    logic          r_oor;
    logic [C-1:0]  r_dx, r_dy;
    logic [PW-1:0] r_a, r_mul;
    logic [CW-1:0] r_nx;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_xo;
    logic [N-1:0]  r_yo;
    logic [C-1:0]  r_x0, r_x1, r_y0, r_y1;
    logic          r_ovalid;
    logic [C-1:0]  r_oxs, r_oxe, r_oys, r_oye;
    logic          r_ooor;

    logic [C-1:0]    w_mop_a;
    logic [CW-1:0]   w_mop_b;
    logic [C+CW-1:0] w_prod;
    logic [PW-1:0]   w_dvd;
    logic [QW-1:0]   w_quot;
    logic [CW-1:0]   w_rem;
    logic            w_div_done;
    logic [PW-1:0]   w_ylo, w_yhi;

    assign w_mop_a = i_cmd.mul_x ? r_dx : r_dy;
    assign w_mop_b = i_cmd.mul_b ? r_count : (i_cmd.mul_x ? r_xo : CW'(r_yo));
    assign w_prod  = w_mop_a * w_mop_b;

    always_comb begin
        case (i_cmd.div_src)
            DSRC_NUM: w_dvd = PW'(r_num);
            DSRC_X0:  w_dvd = r_mul;
            DSRC_X1:  w_dvd = r_mul + PW'(r_dx);
            default:  w_dvd = r_mul;
        endcase
    end

    ist_div #(.DW(PW), .CW(CW), .QW(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (r_nx),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_done     (w_div_done)
    );

    assign w_ylo = r_mul >> r_k;
    assign w_yhi = (r_mul + PW'(r_dy)) >> r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs     <= '0;
            r_xe     <= '0;
            r_ys     <= '0;
            r_ye     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_START: r_xs <= i_cfg_data;
                    CFG_X_END:   r_xe <= i_cfg_data;
                    CFG_Y_START: r_ys <= i_cfg_data;
                    CFG_Y_END:   r_ye <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_num   <= i_tile_number;
            r_count <= i_tile_count;
            r_oor   <= ({1'b0, i_tile_number} >= i_tile_count);
            r_dx    <= (r_xe > r_xs) ? r_xe - r_xs : '0;
            r_dy    <= (r_ye > r_ys) ? r_ye - r_ys : '0;
        end
        if (i_cmd.mul_b || i_cmd.mul_x || i_cmd.mul_y) begin
            r_mul <= PW'(w_prod);
        end else if (i_cmd.step) begin
            r_mul <= r_mul >> 1;
        end
        if (i_cmd.mul_b) begin
            r_a  <= PW'({r_dx, 1'b0});
            r_nx <= r_count;
            r_k  <= '0;
        end else if (i_cmd.step) begin
            r_a  <= r_a << 1;
            r_nx <= r_nx >> 1;
            r_k  <= r_k + 1'b1;
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_src)
                DSRC_NUM: begin
                    r_xo <= w_rem;
                    r_yo <= w_quot[N-1:0];
                end
                DSRC_X0: r_x0 <= r_xs + w_quot[C-1:0];
                DSRC_X1: r_x1 <= r_xs + w_quot[C-1:0];
                default: ;
            endcase
        end
        if (i_cmd.ybnd) begin
            r_y0 <= r_ys + w_ylo[C-1:0];
            r_y1 <= r_ys + w_yhi[C-1:0];
        end
        if (i_cmd.push) begin
            r_oxs <= r_oor ? '0 : r_x0;
            r_oxe <= r_oor ? '0 : r_x1;
            r_oys <= r_oor ? '0 : r_y0;
            r_oye <= r_oor ? '0 : r_y1;
            r_ooor <= r_oor;
        end
    end

    assign o_sts.oor        = r_oor;
    assign o_sts.split_more = ~r_nx[0] && (r_a < r_mul);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_free   = ~r_ovalid || i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_sub_x_start  = r_oxs;
    assign o_sub_x_end    = r_oxe;
    assign o_sub_y_start  = r_oys;
    assign o_sub_y_end    = r_oye;
    assign o_out_of_range = r_ooor;

endmodule

FILE: hw/rtl/ist_ctrl.sv
// Controller state machine sequencing the split, divisions and bound updates.
// Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_ctrl
    import ist_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MULB   = 4'd1;
    localparam logic [3:0] S_SPLIT  = 4'd2;
    localparam logic [3:0] S_DIVN   = 4'd3;
    localparam logic [3:0] S_WDIVN  = 4'd4;
    localparam logic [3:0] S_MULX   = 4'd5;
    localparam logic [3:0] S_DIVX0  = 4'd6;
    localparam logic [3:0] S_WDIVX0 = 4'd7;
    localparam logic [3:0] S_DIVX1  = 4'd8;
    localparam logic [3:0] S_WDIVX1 = 4'd9;
    localparam logic [3:0] S_MULY   = 4'd10;
    localparam logic [3:0] S_YB     = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_MULB;
                end
            end
            S_MULB: begin
                if (i_sts.oor) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_b = 1'b1;
                    n_state     = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (i_sts.split_more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_src = DSRC_NUM;
                n_state       = S_WDIVN;
            end
            S_WDIVN: begin
                o_cmd.div_src = DSRC_NUM;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_MULX;
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_DIVX0;
            end
            S_DIVX0: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_src = DSRC_X0;
                n_state       = S_WDIVX0;
            end
            S_WDIVX0: begin
                o_cmd.div_src = DSRC_X0;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_DIVX1;
                end
            end
            S_DIVX1: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_src = DSRC_X1;
                n_state       = S_WDIVX1;
            end
            S_WDIVX1: begin
                o_cmd.div_src = DSRC_X1;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_MULY;
                end
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_YB;
            end
            S_YB: begin
                o_cmd.ybnd = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
